FILE: rtl/core/sws_pkg.sv
// Shared types, field widths, codes and defaults of the sliding window sender.
`default_nettype none
package sws_pkg;

    localparam int CMD_W     = 2;
    localparam int PAYLOAD_W = 32;
    localparam int ACK_W     = 16;
    localparam int SEQ_W     = 16;
    localparam int WIN_W     = 4;
    localparam int TMO_W     = 16;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int SEQ_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int DUP_LIMIT = 3;

    localparam logic [WIN_W-1:0] WINDOW_RST  = 4'd4;
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2
    } t_cmd;

    typedef struct packed {
        logic load_res;
        logic send;
        logic free;
        logic dup_inc;
        logic dup_clr;
        logic tmr_dec;
        logic tmr_zero;
        logic tmr_stop;
        logic tmr_arm;
        logic emit_head;
    } t_sws_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic win_avail;
        logic nonempty;
        logic ack_ok;
        logic ack_dup;
        logic dup_third;
        logic tmr_run;
        logic tmr_expire;
    } t_sws_stat;

endpackage
`default_nettype wire

FILE: rtl/core/sws_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface sws_in_if;
    logic                          valid;
    logic                          ready;
    logic [sws_pkg::CMD_W-1:0]     cmd;
    logic [sws_pkg::PAYLOAD_W-1:0] payload;
    logic [sws_pkg::ACK_W-1:0]     ack_num;
    logic                          checksum_ok;

    modport source (output valid, cmd, payload, ack_num, checksum_ok, input ready);
    modport sink   (input valid, cmd, payload, ack_num, checksum_ok, output ready);
endinterface

interface sws_out_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic                          pkt_valid;
    logic [sws_pkg::SEQ_W-1:0]     pkt_seq;
    logic [sws_pkg::PAYLOAD_W-1:0] pkt_payload;
    logic                          is_retransmit;
    logic                          window_full;

    modport source (output valid, accepted, pkt_valid, pkt_seq, pkt_payload, is_retransmit,
                    window_full, input ready);
    modport sink   (input valid, accepted, pkt_valid, pkt_seq, pkt_payload, is_retransmit,
                    window_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sws_ctrl.sv
// Controller state machine: handshakes and per-beat command decode.
`default_nettype none
module sws_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_out_ready,
    input  sws_pkg::t_sws_stat  i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output sws_pkg::t_sws_cmd   o_cmd
);
    import sws_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   w_accept;

    assign w_accept    = r_in_ready & i_in_valid;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        if (w_accept) begin
            o_cmd.load_res = 1'b1;
            case (i_stat.cmd)
                CMD_SEND: begin
                    if (i_stat.win_avail) begin
                        o_cmd.send    = 1'b1;
                        o_cmd.tmr_arm = 1'b1;
                    end
                end
                CMD_ACK: begin
                    if (i_stat.ack_ok) begin
                        if (i_stat.nonempty && i_stat.ack_dup) begin
                            if (i_stat.dup_third) begin
                                o_cmd.dup_clr   = 1'b1;
                                o_cmd.tmr_arm   = 1'b1;
                                o_cmd.emit_head = 1'b1;
                            end else begin
                                o_cmd.dup_inc = 1'b1;
                            end
                        end else begin
                            o_cmd.dup_clr = 1'b1;
                            o_cmd.free    = i_stat.nonempty;
                        end
                    end
                end
                CMD_TICK: begin
                    if (i_stat.tmr_run) begin
                        if (!i_stat.tmr_expire) begin
                            o_cmd.tmr_dec = 1'b1;
                        end else begin
                            o_cmd.tmr_zero = 1'b1;
                            if (i_stat.nonempty) begin
                                o_cmd.emit_head = 1'b1;
                                o_cmd.tmr_arm   = 1'b1;
                            end else begin
                                o_cmd.tmr_stop = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_in_ready <= 1'b1;
                    if (w_accept) begin
                        r_state     <= S_OUT;
                        r_in_ready  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b0;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/sws_dp.sv
// Datapath: window bookkeeping, payload store, retransmit timer and result register.
`default_nettype none
module sws_dp #(
    parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF,
    parameter int SEQ_BITS     = sws_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  sws_pkg::t_sws_cmd               i_cmd,
    output sws_pkg::t_sws_stat              o_stat,
    input  wire  [sws_pkg::CMD_W-1:0]       i_item_cmd,
    input  wire  [sws_pkg::PAYLOAD_W-1:0]   i_payload,
    input  wire  [sws_pkg::ACK_W-1:0]       i_ack_num,
    input  wire                             i_checksum_ok,
    input  wire  [sws_pkg::WIN_W-1:0]       i_window_size,
    input  wire  [sws_pkg::TMO_W-1:0]       i_timeout_ticks,
    output logic                            o_accepted,
    output logic                            o_pkt_valid,
    output logic [sws_pkg::SEQ_W-1:0]       o_pkt_seq,
    output logic [sws_pkg::PAYLOAD_W-1:0]   o_pkt_payload,
    output logic                            o_is_retransmit,
    output logic                            o_window_full
);
    import sws_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int SP_W  = (SEQ_BITS + 1 > CNT_W) ? SEQ_BITS + 1 : CNT_W;

    function automatic logic [IDX_W-1:0] f_wrap(input logic [SUM_W-1:0] s);
        logic [IDX_W-1:0] r;
        if (s >= SUM_W'(WINDOW_DEPTH)) begin
            r = IDX_W'(s - SUM_W'(WINDOW_DEPTH));
        end else begin
            r = IDX_W'(s);
        end
        return r;
    endfunction

    logic [PAYLOAD_BITS-1:0] r_store [WINDOW_DEPTH];
    logic [IDX_W-1:0]        r_head,      n_head;
    logic [CNT_W-1:0]        r_in_flight, n_in_flight;
    logic [SEQ_BITS-1:0]     r_last_seq,  n_last_seq;
    logic [1:0]              r_dup,       n_dup;
    logic [TMO_W-1:0]        r_left,      n_left;
    logic                    r_run,       n_run;

    logic [CMP_W-1:0]    w_effw;
    logic [SEQ_BITS-1:0] w_head_seq;
    logic [SEQ_BITS-1:0] w_ack;
    logic [SEQ_BITS-1:0] w_diff;
    logic [SEQ_BITS-1:0] w_ahead;
    logic [SEQ_BITS-1:0] w_next_seq;
    logic [SP_W-1:0]     w_span;
    logic [CNT_W-1:0]    w_freed;
    logic [IDX_W-1:0]    w_slot;

    assign w_effw = (CMP_W'(i_window_size) > CMP_W'(WINDOW_DEPTH)) ?
                    CMP_W'(WINDOW_DEPTH) : CMP_W'(i_window_size);
    assign w_head_seq = r_last_seq - SEQ_BITS'(r_in_flight) + SEQ_BITS'(1);
    assign w_next_seq = r_last_seq + SEQ_BITS'(1);
    assign w_ack      = SEQ_BITS'(i_ack_num);
    assign w_diff     = w_head_seq - w_ack;
    assign w_ahead    = w_ack - w_head_seq;
    assign w_span     = SP_W'(w_ahead) + SP_W'(1);
    assign w_freed    = (w_span >= SP_W'(r_in_flight)) ? r_in_flight : CNT_W'(w_span);
    assign w_slot     = f_wrap(SUM_W'(r_head) + SUM_W'(r_in_flight));

    always_comb begin
        o_stat.cmd        = t_cmd'(i_item_cmd);
        o_stat.win_avail  = CMP_W'(r_in_flight) < w_effw;
        o_stat.nonempty   = r_in_flight != '0;
        o_stat.ack_ok     = i_checksum_ok;
        o_stat.ack_dup    = (w_diff != '0) && !w_diff[SEQ_BITS-1];
        o_stat.dup_third  = r_dup >= 2'(DUP_LIMIT - 1);
        o_stat.tmr_run    = r_run;
        o_stat.tmr_expire = r_left <= TMO_W'(1);
    end

    always_comb begin
        n_head      = r_head;
        n_in_flight = r_in_flight;
        n_last_seq  = r_last_seq;
        n_dup       = r_dup;
        n_left      = r_left;
        n_run       = r_run;
        if (i_cmd.send) begin
            n_last_seq  = w_next_seq;
            n_in_flight = r_in_flight + CNT_W'(1);
        end
        if (i_cmd.free) begin
            n_head      = f_wrap(SUM_W'(r_head) + SUM_W'(w_freed));
            n_in_flight = r_in_flight - w_freed;
        end
        if (i_cmd.dup_inc) begin
            n_dup = r_dup + 2'd1;
        end
        if (i_cmd.dup_clr) begin
            n_dup = 2'd0;
        end
        if (i_cmd.tmr_dec) begin
            n_left = r_left - TMO_W'(1);
        end
        if (i_cmd.tmr_zero) begin
            n_left = '0;
        end
        if (i_cmd.tmr_stop) begin
            n_run = 1'b0;
        end
        if (i_cmd.tmr_arm) begin
            n_left = i_timeout_ticks;
            n_run  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_in_flight <= '0;
            r_last_seq  <= '0;
            r_dup       <= '0;
            r_left      <= '0;
            r_run       <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_in_flight <= n_in_flight;
            r_last_seq  <= n_last_seq;
            r_dup       <= n_dup;
            r_left      <= n_left;
            r_run       <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            r_store[w_slot] <= PAYLOAD_BITS'(i_payload);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            o_accepted      <= i_cmd.send;
            o_pkt_valid     <= i_cmd.send | i_cmd.emit_head;
            o_is_retransmit <= i_cmd.emit_head;
            o_window_full   <= CMP_W'(n_in_flight) >= w_effw;
            if (i_cmd.send) begin
                o_pkt_seq     <= SEQ_W'(w_next_seq);
                o_pkt_payload <= PAYLOAD_W'(PAYLOAD_BITS'(i_payload));
            end else if (i_cmd.emit_head) begin
                o_pkt_seq     <= SEQ_W'(w_head_seq);
                o_pkt_payload <= PAYLOAD_W'(r_store[r_head]);
            end else begin
                o_pkt_seq     <= '0;
                o_pkt_payload <= '0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/sliding_window_sender_unit.sv
// Top level of the sliding window sender: register port, controller and datapath.
// Latency: the result beat is valid in the cycle after the input beat is taken.
// The controller holds the input side until the pending result beat has been
// taken, so no new item is accepted while a result beat is pending.
// Every item, send, ack or tick, yields exactly one result beat.
// Reset is synchronous and active low; it empties the window, stops the timer
// and loads the register defaults (window 4, timeout 1000 ticks).
`default_nettype none
module sliding_window_sender_unit #(
    parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF,
    parameter int SEQ_BITS     = sws_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    sws_in_if.sink                          i_in,
    sws_out_if.source                       o_out,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [sws_pkg::PADDR_W-1:0]     paddr,
    input  wire  [sws_pkg::PDATA_W-1:0]     pwdata,
    output logic [sws_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import sws_pkg::*;

    logic [WIN_W-1:0]     r_window_size;
    logic [TMO_W-1:0]     r_timeout_ticks;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_wr;
    t_sws_cmd             w_cmd;
    t_sws_stat            w_stat;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];
    assign w_wr      = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= WINDOW_RST;
            r_timeout_ticks <= TIMEOUT_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_WINDOW_SIZE:   r_window_size   <= pwdata[WIN_W-1:0];
                REG_TIMEOUT_TICKS: r_timeout_ticks <= pwdata[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_WINDOW_SIZE:   prdata = PDATA_W'(r_window_size);
            REG_TIMEOUT_TICKS: prdata = PDATA_W'(r_timeout_ticks);
            default:           prdata = '0;
        endcase
    end

    sws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    sws_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_item_cmd      (i_in.cmd),
        .i_payload       (i_in.payload),
        .i_ack_num       (i_in.ack_num),
        .i_checksum_ok   (i_in.checksum_ok),
        .i_window_size   (r_window_size),
        .i_timeout_ticks (r_timeout_ticks),
        .o_accepted      (o_out.accepted),
        .o_pkt_valid     (o_out.pkt_valid),
        .o_pkt_seq       (o_out.pkt_seq),
        .o_pkt_payload   (o_out.pkt_payload),
        .o_is_retransmit (o_out.is_retransmit),
        .o_window_full   (o_out.window_full)
    );
endmodule
`default_nettype wire

FILE: rtl/core/sws_checker.sv
// Port-level assertions for the sliding window sender and their bind.
`default_nettype none
module sws_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire                           i_accepted,
    input wire                           i_pkt_valid,
    input wire [sws_pkg::SEQ_W-1:0]      i_pkt_seq,
    input wire [sws_pkg::PAYLOAD_W-1:0]  i_pkt_payload,
    input wire                           i_is_retransmit
);
    a_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result beat in the cycle after an input beat");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a result beat is pending");

    a_send_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> i_pkt_valid && !i_is_retransmit)
        else $error("accepted send without a fresh packet");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_pkt_valid |->
            i_pkt_seq == '0 && i_pkt_payload == '0 && !i_is_retransmit && !i_accepted)
        else $error("result fields set without a packet");
endmodule

bind sliding_window_sender_unit sws_checker u_sws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_accepted      (o_out.accepted),
    .i_pkt_valid     (o_out.pkt_valid),
    .i_pkt_seq       (o_out.pkt_seq),
    .i_pkt_payload   (o_out.pkt_payload),
    .i_is_retransmit (o_out.is_retransmit)
);
`default_nettype wire
